### hw/rtl/crc32_combine_gf2_defines.svh
// ---------------------------------------------------------------------------
// crc32_combine_gf2 assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef CRC32_COMBINE_GF2_DEFINES_SVH
`define CRC32_COMBINE_GF2_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define C32C_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("c32c assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define C32C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("c32c assertion failed");

`endif

### hw/rtl/c32c_pkg.sv
// ---------------------------------------------------------------------------
// c32c_pkg
// Types, constants and the one-zero-bit operator for the CRC-32 combiner.
// ---------------------------------------------------------------------------
package c32c_pkg;

    localparam int CRC_W           = 32;
    localparam int MAT_DIM         = 32;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int PRE_SQUARINGS   = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    typedef logic [CRC_W-1:0]              t_row;
    typedef logic [MAT_DIM-1:0][CRC_W-1:0] t_mat;

    // Operator that shifts one zero bit through the reflected CRC register.
    function automatic t_mat one_bit_op();
        t_mat m;
        m[0] = CRC_POLY;
        for (int i = 1; i < MAT_DIM; i++) begin
            m[i] = t_row'(1) << (i - 1);
        end
        return m;
    endfunction

endpackage

### hw/rtl/c32c_matvec.sv
// ---------------------------------------------------------------------------
// c32c_matvec
// GF(2) matrix times vector: XOR of the rows selected by the vector's bits.
// ---------------------------------------------------------------------------
module c32c_matvec
    import c32c_pkg::*;
(
    input  t_mat i_mat,
    input  t_row i_vec,
    output t_row o_prod
);

    // Each output bit is the parity of one column masked by the vector.
    always_comb begin
        logic [MAT_DIM-1:0] col;
        for (int j = 0; j < CRC_W; j++) begin
            for (int i = 0; i < MAT_DIM; i++) begin
                col[i] = i_mat[i][j];
            end
            o_prod[j] = ^(col & i_vec);
        end
    end

endmodule

### hw/rtl/crc32_combine_gf2.sv
// When the used length bits are zero, o_done rises in the cycle after accept; otherwise
// three squarings precede the first bit step, and one more precedes each later length bit.
// A squaring is one row product per cycle on the shared unit followed by a copy,
// and every length bit takes one bit step for its optional apply.
// A new transaction is accepted only once the block is idle again after o_done; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle with no result pending.
// ---------------------------------------------------------------------------
// crc32_combine_gf2
// Joins two reflected CRC-32 values given the length of the second block,
// by repeated squaring of the zero-bit operator as a 32x32 GF(2) matrix.
// ---------------------------------------------------------------------------
`include "crc32_combine_gf2_defines.svh"

module crc32_combine_gf2
    import c32c_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CRC_W-1:0] i_first_crc,
    input  logic [CRC_W-1:0] i_second_crc,
    input  logic [CRC_W-1:0] i_second_length,
    output logic             o_done,
    output logic [CRC_W-1:0] o_combined_crc
);

    // Only the low LENGTH_BITS bits of the length take part; the port is
    // 32 bits wide, so at most 32 bits are kept.
    localparam int LEN_W = (LENGTH_BITS < CRC_W) ? LENGTH_BITS : CRC_W;
    localparam int ROW_W = $clog2(MAT_DIM);
    localparam int PRE_W = $clog2(PRE_SQUARINGS + 1);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAT_DIM - 1);

    // The sequencer walks through the squaring of the operator row by row,
    // copies the new operator into place and, after the pre-squarings, handles one length bit.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_COPY = 5'b00100,
        S_BIT  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row,   n_row;
    logic [PRE_W-1:0] r_pre,   n_pre;
    logic [LEN_W-1:0] r_len,   n_len;
    t_row             r_acc,   n_acc;
    t_row             r_other, n_other;
    t_row             r_res,   n_res;

    // Current operator and the matrix being built by the squaring.
    t_mat r_op;
    t_mat r_tmp;

    t_row mv_vec;
    t_row mv_prod;
    logic accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // The shared unit always multiplies by the current operator. During a
    // squaring the vector is the operator's own row; in a bit step it is the
    // running CRC.
    assign mv_vec = (r_state == S_BIT) ? r_acc : r_op[r_row];

    c32c_matvec u_matvec (
        .i_mat  (r_op),
        .i_vec  (mv_vec),
        .o_prod (mv_prod)
    );

    always_comb begin
        logic [LEN_W-1:0] len_shift;
        n_state   = r_state;
        n_row     = r_row;
        n_pre     = r_pre;
        n_len     = r_len;
        n_acc     = r_acc;
        n_other   = r_other;
        n_res     = r_res;
        len_shift = r_len >> 1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_acc   = i_first_crc;
                    n_other = i_second_crc;
                    n_len   = i_second_length[LEN_W-1:0];
                    n_row   = '0;
                    if (i_second_length[LEN_W-1:0] == '0) begin
                        // A zero length passes the first CRC through untouched.
                        n_res   = i_first_crc;
                        n_state = S_DONE;
                    end else begin
                        n_pre   = PRE_W'(PRE_SQUARINGS);
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                n_row = r_row + 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                // The first three squarings turn the bit operator into the
                // byte operator; later ones follow each length bit.
                if (r_pre > PRE_W'(1)) begin
                    n_pre   = r_pre - 1'b1;
                    n_state = S_SQ;
                end else begin
                    n_pre   = '0;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (r_len[0]) begin
                    n_acc = mv_prod;
                end
                n_len = len_shift;
                if (len_shift != '0) begin
                    n_state = S_SQ;
                end else begin
                    n_res   = n_acc ^ r_other;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_pre   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_pre   <= n_pre;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_other <= n_other;
        r_res   <= n_res;
    end

    // Operator storage: loaded on acceptance, one row of the square written
    // per cycle, then the whole square copied back at once.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_op <= one_bit_op();
        end else if (r_state == S_COPY) begin
            r_op <= r_tmp;
        end
        if (r_state == S_SQ) begin
            r_tmp[r_row] <= mv_prod;
        end
    end

    assign o_done         = (r_state == S_DONE);
    assign o_combined_crc = r_res;

    // An accepted transaction always makes the block busy in the next cycle.
    `C32C_ASSERT_NEXT(a_accept_busy, accept, busy)
    // After the result strobe the block is free again.
    `C32C_ASSERT_NEXT(a_done_idle, o_done, !busy)
    // The row counter rests at zero outside a squaring.
    `C32C_ASSERT_SAME(a_row_rest, r_row != '0, r_state == S_SQ)
    // Pre-squarings only remain while a squaring or its copy is under way.
    `C32C_ASSERT_SAME(a_pre_phase, r_pre != '0, r_state == S_SQ || r_state == S_COPY)
    // A bit step is only ever reached with length bits still to handle.
    `C32C_ASSERT_SAME(a_bit_len, r_state == S_BIT, r_len != '0)

endmodule
